FILE: rtl/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg: shared types and constants for the mecanum wheel mixer
// Stage counts, field widths, angle constants and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package mwm_pkg;

   localparam int DEF_FULL_SCALE_IN = 100;
   localparam int DEF_DUTY_MAX      = 255;

   localparam int NUM_WHEELS    = 4;
   localparam int ANGLE_STAGES  = 5;
   localparam int MIX_STAGES    = 2;
   localparam int DUTY_STAGES   = 4;
   localparam int NUM_STAGES    = ANGLE_STAGES + MIX_STAGES + DUTY_STAGES;

   localparam int HEADING_W = 16;
   localparam int CMD_W     = 8;
   localparam int DUTY_W    = 8;
   localparam int MASK_W    = 4;

   localparam int DEG_FULL    = 360;
   localparam int DEG_HALF    = 180;
   localparam int DEG_QUARTER = 90;
   localparam int DEG_THREEQ  = 270;

   // heading is offset by 2^15 to make it unsigned; this is its residue mod 360
   localparam int HEAD_OFS   = (1 << (HEADING_W - 1)) % DEG_FULL;
   localparam int HEAD_SHIFT = 24;
   localparam int HEAD_RECIP = (1 << HEAD_SHIFT) / DEG_FULL;
   localparam int HEAD_Q_W   = 8;

   localparam int TRIG_W   = 17;   // signed Q1.15 with +1.0 representable
   localparam int FRAC_W   = 15;
   localparam int PROD_W   = 25;
   localparam int SUM_W    = 26;
   localparam int MAG_W    = 9;

   typedef struct packed {
      logic signed [TRIG_W-1:0] sine;
      logic signed [TRIG_W-1:0] cosine;
      logic signed [CMD_W-1:0]  speed;
      logic signed [CMD_W-1:0]  rotation;
   } mwm_trig_type;

   typedef struct packed {
      logic             pos;   // truncated power strictly above zero
      logic [MAG_W-1:0] mag;   // |power| after truncation toward zero
   } mwm_power_type;

   function automatic logic [15:0] sine_quarter(input logic [6:0] idx);
      logic [15:0] v;
      case (idx)
         7'd0: v = 16'd0;          7'd1: v = 16'd572;        7'd2: v = 16'd1144;
         7'd3: v = 16'd1715;       7'd4: v = 16'd2286;       7'd5: v = 16'd2856;
         7'd6: v = 16'd3425;       7'd7: v = 16'd3993;       7'd8: v = 16'd4560;
         7'd9: v = 16'd5126;       7'd10: v = 16'd5690;      7'd11: v = 16'd6252;
         7'd12: v = 16'd6813;      7'd13: v = 16'd7371;      7'd14: v = 16'd7927;
         7'd15: v = 16'd8481;      7'd16: v = 16'd9032;      7'd17: v = 16'd9580;
         7'd18: v = 16'd10126;     7'd19: v = 16'd10668;     7'd20: v = 16'd11207;
         7'd21: v = 16'd11743;     7'd22: v = 16'd12275;     7'd23: v = 16'd12804;
         7'd24: v = 16'd13328;     7'd25: v = 16'd13848;     7'd26: v = 16'd14365;
         7'd27: v = 16'd14876;     7'd28: v = 16'd15384;     7'd29: v = 16'd15886;
         7'd30: v = 16'd16384;     7'd31: v = 16'd16877;     7'd32: v = 16'd17364;
         7'd33: v = 16'd17847;     7'd34: v = 16'd18324;     7'd35: v = 16'd18795;
         7'd36: v = 16'd19261;     7'd37: v = 16'd19720;     7'd38: v = 16'd20174;
         7'd39: v = 16'd20622;     7'd40: v = 16'd21063;     7'd41: v = 16'd21498;
         7'd42: v = 16'd21926;     7'd43: v = 16'd22348;     7'd44: v = 16'd22763;
         7'd45: v = 16'd23170;     7'd46: v = 16'd23571;     7'd47: v = 16'd23965;
         7'd48: v = 16'd24351;     7'd49: v = 16'd24730;     7'd50: v = 16'd25102;
         7'd51: v = 16'd25466;     7'd52: v = 16'd25822;     7'd53: v = 16'd26170;
         7'd54: v = 16'd26510;     7'd55: v = 16'd26842;     7'd56: v = 16'd27166;
         7'd57: v = 16'd27482;     7'd58: v = 16'd27789;     7'd59: v = 16'd28088;
         7'd60: v = 16'd28378;     7'd61: v = 16'd28660;     7'd62: v = 16'd28932;
         7'd63: v = 16'd29197;     7'd64: v = 16'd29452;     7'd65: v = 16'd29698;
         7'd66: v = 16'd29935;     7'd67: v = 16'd30163;     7'd68: v = 16'd30382;
         7'd69: v = 16'd30592;     7'd70: v = 16'd30792;     7'd71: v = 16'd30983;
         7'd72: v = 16'd31164;     7'd73: v = 16'd31336;     7'd74: v = 16'd31499;
         7'd75: v = 16'd31651;     7'd76: v = 16'd31795;     7'd77: v = 16'd31928;
         7'd78: v = 16'd32052;     7'd79: v = 16'd32166;     7'd80: v = 16'd32270;
         7'd81: v = 16'd32365;     7'd82: v = 16'd32449;     7'd83: v = 16'd32523;
         7'd84: v = 16'd32588;     7'd85: v = 16'd32643;     7'd86: v = 16'd32688;
         7'd87: v = 16'd32723;     7'd88: v = 16'd32748;     7'd89: v = 16'd32763;
         7'd90: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/mwm_angle.sv
// ----------------------------------------------------------------------------
// mwm_angle: heading to sine and cosine
// Reduces the heading mod 360, adds 90 degrees for the sine and 180 for the
// cosine, and looks up the signed Q1.15 values. Speed and rotation ride along.
// ----------------------------------------------------------------------------
module mwm_angle
   import mwm_pkg::*;
(
   input  logic                        clock,
   input  logic [ANGLE_STAGES-1:0]     en,
   input  logic signed [HEADING_W-1:0] heading_deg,
   input  logic signed [CMD_W-1:0]     speed,
   input  logic signed [CMD_W-1:0]     rotation,
   output mwm_trig_type                trig
);

   typedef struct packed {
      logic [1:0] quad;
      logic [6:0] rem;
   } quad_type;

   function automatic quad_type quad_split(input logic [8:0] a);
      quad_type res;
      if (a >= 9'(DEG_THREEQ)) begin
         res.quad = 2'd3;
         res.rem  = 7'(a - 9'(DEG_THREEQ));
      end else if (a >= 9'(DEG_HALF)) begin
         res.quad = 2'd2;
         res.rem  = 7'(a - 9'(DEG_HALF));
      end else if (a >= 9'(DEG_QUARTER)) begin
         res.quad = 2'd1;
         res.rem  = 7'(a - 9'(DEG_QUARTER));
      end else begin
         res.quad = 2'd0;
         res.rem  = 7'(a);
      end
      return res;
   endfunction

   function automatic logic signed [TRIG_W-1:0] trig_lookup(input quad_type qr);
      logic [6:0]               idx;
      logic signed [TRIG_W-1:0] m;
      idx = qr.quad[0] ? 7'(7'(DEG_QUARTER) - qr.rem) : qr.rem;
      m   = $signed({1'b0, sine_quarter(idx)});
      return qr.quad[1] ? -m : m;
   endfunction

   // stage 1: offset to unsigned, reciprocal multiply for the quotient by 360
   logic [HEADING_W-1:0] u_in, u_ff;
   logic [HEAD_Q_W-1:0]  qh_in, qh_ff;
   logic [31:0]          hprod;

   // stage 2: first remainder, below 720
   logic [16:0]          diff;
   logic [9:0]           r0_in, r0_ff;

   // stage 3: heading mod 360
   logic [9:0]           r1, red10;
   logic [8:0]           red_in, red_ff;

   // stage 4: angle of the sine and the cosine, split into quadrants
   logic [9:0]           as10, ac10;
   quad_type             qs_in, qs_ff, qc_in, qc_ff;

   // stage 5: table lookup
   logic signed [TRIG_W-1:0] sine_in, sine_ff, cos_in, cos_ff;

   logic signed [CMD_W-1:0] spd_ff [ANGLE_STAGES];
   logic signed [CMD_W-1:0] rot_ff [ANGLE_STAGES];

   always_comb begin
      u_in   = {~heading_deg[HEADING_W-1], heading_deg[HEADING_W-2:0]};
      hprod  = 32'(u_in) * 32'(HEAD_RECIP);
      qh_in  = hprod[HEAD_SHIFT+HEAD_Q_W-1:HEAD_SHIFT];

      diff   = {1'b0, u_ff} - 17'(qh_ff) * 17'(DEG_FULL);
      r0_in  = diff[9:0];

      r1     = (r0_ff >= 10'(DEG_FULL)) ? 10'(r0_ff - 10'(DEG_FULL)) : r0_ff;
      red10  = (r1 >= 10'(HEAD_OFS)) ? 10'(r1 - 10'(HEAD_OFS))
                                     : 10'(r1 + 10'(DEG_FULL - HEAD_OFS));
      red_in = red10[8:0];

      as10   = {1'b0, red_ff} + 10'(DEG_QUARTER);
      if (as10 >= 10'(DEG_FULL)) begin
         as10 = 10'(as10 - 10'(DEG_FULL));
      end
      ac10   = {1'b0, red_ff} + 10'(DEG_HALF);
      if (ac10 >= 10'(DEG_FULL)) begin
         ac10 = 10'(ac10 - 10'(DEG_FULL));
      end
      qs_in  = quad_split(as10[8:0]);
      qc_in  = quad_split(ac10[8:0]);

      sine_in = trig_lookup(qs_ff);
      cos_in  = trig_lookup(qc_ff);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u_ff      <= u_in;
         qh_ff     <= qh_in;
         spd_ff[0] <= speed;
         rot_ff[0] <= rotation;
      end
      if (en[1]) begin
         r0_ff <= r0_in;
      end
      if (en[2]) begin
         red_ff <= red_in;
      end
      if (en[3]) begin
         qs_ff <= qs_in;
         qc_ff <= qc_in;
      end
      if (en[4]) begin
         sine_ff <= sine_in;
         cos_ff  <= cos_in;
      end
      for (int i = 1; i < ANGLE_STAGES; i++) begin
         if (en[i]) begin
            spd_ff[i] <= spd_ff[i-1];
            rot_ff[i] <= rot_ff[i-1];
         end
      end
   end

   assign trig.sine     = sine_ff;
   assign trig.cosine   = cos_ff;
   assign trig.speed    = spd_ff[ANGLE_STAGES-1];
   assign trig.rotation = rot_ff[ANGLE_STAGES-1];

endmodule

FILE: rtl/mwm_mix.sv
// ----------------------------------------------------------------------------
// mwm_mix: wheel power mixing
// Multiplies speed by sine and cosine, forms the four wheel sums and
// truncates each toward zero to sign and magnitude.
// ----------------------------------------------------------------------------
module mwm_mix
   import mwm_pkg::*;
(
   input  logic                                clock,
   input  logic [MIX_STAGES-1:0]               en,
   input  mwm_trig_type                        trig,
   output mwm_power_type [NUM_WHEELS-1:0]      power
);

   logic signed [PROD_W-1:0] s_in, s_ff, c_in, c_ff;
   logic signed [CMD_W-1:0]  rot_ff;

   logic signed [SUM_W-1:0]  ss, cc, rq;
   logic signed [SUM_W-1:0]  sums [NUM_WHEELS];
   logic [SUM_W-1:0]         absv [NUM_WHEELS];
   mwm_power_type [NUM_WHEELS-1:0] power_in, power_ff;

   always_comb begin
      s_in = PROD_W'(trig.speed) * PROD_W'(trig.sine);
      c_in = PROD_W'(trig.speed) * PROD_W'(trig.cosine);

      ss = SUM_W'(s_ff);
      cc = SUM_W'(c_ff);
      rq = SUM_W'(rot_ff) <<< FRAC_W;

      sums[0] = ss + cc - rq;
      sums[1] = ss - cc + rq;
      sums[2] = ss + cc + rq;
      sums[3] = ss - cc - rq;

      for (int w = 0; w < NUM_WHEELS; w++) begin
         absv[w] = sums[w][SUM_W-1] ? SUM_W'(-sums[w]) : SUM_W'(sums[w]);
         power_in[w].mag = absv[w][FRAC_W+MAG_W-1:FRAC_W];
         power_in[w].pos = !sums[w][SUM_W-1] && (power_in[w].mag != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s_ff   <= s_in;
         c_ff   <= c_in;
         rot_ff <= trig.rotation;
      end
      if (en[1]) begin
         power_ff <= power_in;
      end
   end

   assign power = power_ff;

endmodule

FILE: rtl/mwm_duty.sv
// ----------------------------------------------------------------------------
// mwm_duty: magnitude to duty for one wheel
// duty = mag * DUTY_MAX / FULL_SCALE_IN, truncated and saturated; the
// quotient comes from a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module mwm_duty
   import mwm_pkg::*;
#(
   parameter int FULL_SCALE_IN = DEF_FULL_SCALE_IN,
   parameter int DUTY_MAX      = DEF_DUTY_MAX
) (
   input  logic                   clock,
   input  logic [DUTY_STAGES-1:0] en,
   input  mwm_power_type          power,
   input  logic                   invert,
   output logic [DUTY_W-1:0]      duty_fwd,
   output logic [DUTY_W-1:0]      duty_rev
);

   localparam int DW = $clog2(DUTY_MAX + 1);
   localparam int PW = MAG_W + DW;
   localparam int RW = $clog2(2 * FULL_SCALE_IN);
   localparam logic [PW:0] RECIP = (PW + 1)'((1 << PW) / FULL_SCALE_IN);

   logic [PW-1:0]   p_in, p8_ff, p9_ff;
   logic            sat8_ff, sat9_ff, sat10_ff;
   logic            pos8_ff, pos9_ff, pos10_ff;
   logic [2*PW:0]   prod;
   logic [PW-1:0]   q0_in, q9_ff, q10_ff;
   logic [RW-1:0]   r_in, r_ff;
   logic [DW-1:0]   duty;
   logic            dir;
   logic [DUTY_W-1:0] fwd_in, fwd_ff, rev_in, rev_ff;

   always_comb begin
      p_in  = PW'(power.mag) * PW'(DUTY_MAX);
      prod  = (2*PW+1)'(p8_ff) * (2*PW+1)'(RECIP);
      q0_in = prod[2*PW-1:PW];
      // q9 is the quotient or one less, so the remainder stays below 2F
      r_in  = RW'(p9_ff - q9_ff * PW'(FULL_SCALE_IN));
      duty  = sat10_ff ? DW'(DUTY_MAX)
                       : DW'(q10_ff + PW'(r_ff >= RW'(FULL_SCALE_IN)));
      dir    = pos10_ff ^ invert;
      fwd_in = dir ? DUTY_W'(duty) : '0;
      rev_in = dir ? '0 : DUTY_W'(duty);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p8_ff   <= p_in;
         sat8_ff <= int'(power.mag) >= FULL_SCALE_IN;
         pos8_ff <= power.pos;
      end
      if (en[1]) begin
         p9_ff   <= p8_ff;
         q9_ff   <= q0_in;
         sat9_ff <= sat8_ff;
         pos9_ff <= pos8_ff;
      end
      if (en[2]) begin
         r_ff     <= r_in;
         q10_ff   <= q9_ff;
         sat10_ff <= sat9_ff;
         pos10_ff <= pos9_ff;
      end
      if (en[3]) begin
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
      end
   end

   assign duty_fwd = fwd_ff;
   assign duty_rev = rev_ff;

endmodule

FILE: rtl/mecanum_wheel_mixer.sv
// Throughput: one item per cycle; the eleven pipeline stages advance
// independently, so bubbles close up and req_tready drops only when every
// stage holds an item and rsp_tready is low.
// Reset: clears the stage valid bits and the wheel invert mask.
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer: four-wheel mecanum drive mixer
// Heading, speed and rotation in; two duty values per wheel out.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer
   import mwm_pkg::*;
#(
   parameter int FULL_SCALE_IN = DEF_FULL_SCALE_IN,
   parameter int DUTY_MAX      = DEF_DUTY_MAX
) (
   input  logic               clock,
   input  logic               reset,
   // req_tdata: heading_deg[15:0], speed[23:16], rotation[31:24]
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,
   // rsp_tdata: wheel0_duty_fwd, wheel0_duty_rev, wheel1_duty_fwd, ...,
   //            wheel3_duty_rev, 8 bits each from bit 0 up
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [63:0]        rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [MASK_W-1:0]  csr_wdata
);

   logic [NUM_STAGES-1:0] vld_ff, vld_in, stage_en;
   logic [MASK_W-1:0]     mask_ff, mask_in;

   mwm_trig_type                   trig;
   mwm_power_type [NUM_WHEELS-1:0] power;
   logic [DUTY_W-1:0]              duty_fwd [NUM_WHEELS];
   logic [DUTY_W-1:0]              duty_rev [NUM_WHEELS];

   // a stage may load unless it and every stage after it are full and stalled
   always_comb begin
      for (int i = 0; i < NUM_STAGES; i++) begin
         stage_en[i] = rsp_tready ||
                       !(&(vld_ff | NUM_STAGES'((1 << i) - 1)));
      end
      vld_in = vld_ff;
      if (stage_en[0]) begin
         vld_in[0] = req_tvalid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (stage_en[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
      mask_in = (csr_valid && csr_ready) ? csr_wdata : mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mask_ff <= '0;
      end else begin
         vld_ff  <= vld_in;
         mask_ff <= mask_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = vld_ff[NUM_STAGES-1];
   assign csr_ready  = 1'b1;

   mwm_angle u_angle (
      .clock       (clock),
      .en          (stage_en[ANGLE_STAGES-1:0]),
      .heading_deg ($signed(req_tdata[15:0])),
      .speed       ($signed(req_tdata[23:16])),
      .rotation    ($signed(req_tdata[31:24])),
      .trig        (trig)
   );

   mwm_mix u_mix (
      .clock (clock),
      .en    (stage_en[ANGLE_STAGES+MIX_STAGES-1:ANGLE_STAGES]),
      .trig  (trig),
      .power (power)
   );

   for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
      mwm_duty #(
         .FULL_SCALE_IN (FULL_SCALE_IN),
         .DUTY_MAX      (DUTY_MAX)
      ) u_duty (
         .clock    (clock),
         .en       (stage_en[NUM_STAGES-1:ANGLE_STAGES+MIX_STAGES]),
         .power    (power[w]),
         .invert   (mask_ff[w]),
         .duty_fwd (duty_fwd[w]),
         .duty_rev (duty_rev[w])
      );
      assign rsp_tdata[w*2*DUTY_W +: DUTY_W]          = duty_fwd[w];
      assign rsp_tdata[w*2*DUTY_W + DUTY_W +: DUTY_W] = duty_rev[w];
   end

`ifndef NO_ASSERTIONS
   // one of each wheel's two duties is always zero
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((rsp_tdata[7:0] != 8'd0) && (rsp_tdata[15:8] != 8'd0)) &&
                     !((rsp_tdata[23:16] != 8'd0) && (rsp_tdata[31:24] != 8'd0)) &&
                     !((rsp_tdata[39:32] != 8'd0) && (rsp_tdata[47:40] != 8'd0)) &&
                     !((rsp_tdata[55:48] != 8'd0) && (rsp_tdata[63:56] != 8'd0)))
      else $error("both duties of a wheel nonzero");

   // input back-pressure only comes from a stalled result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without output stall");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result presented right after reset");
`endif

endmodule
